FILE: sv/sliding_window_rate_limiter_macros.svh
// Assertion macros for the sliding window rate limiter.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

// check cons in the same cycle as ante
`define SWRL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// check cons in the cycle after ante
`define SWRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/swrl_pkg.sv
// Shared types and constants for the sliding window rate limiter.
// No dependencies.
package swrl_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam int ARRIVAL_W   = 32;
    localparam int MAX_W       = 8;
    localparam int WIN_W       = 16;
    localparam int IN_WINDOW_W = 9;

    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [MAX_W-1:0] MAX_PER_WINDOW_RST = 8'd50;
    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST  = 16'd1000;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PER_WINDOW = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH  = 1'd1;

    typedef struct packed {
        logic [MAX_W-1:0] max_per_window;
        logic [WIN_W-1:0] window_length;
    } cfg_t;

endpackage

FILE: sv/swrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/swrl_cfg_regs.sv
// Configuration registers: limit and window length.
// Depends on swrl_pkg.
module swrl_cfg_regs import swrl_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_PER_WINDOW: cfg_next.max_per_window = cfg_wdata[MAX_W-1:0];
                REG_WINDOW_LENGTH:  cfg_next.window_length  = cfg_wdata[WIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_per_window <= MAX_PER_WINDOW_RST;
            cfg_reg.window_length  <= WINDOW_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/sliding_window_rate_limiter.sv
// Channel  | Dir | Payload (low bit first)                   | Accept
// s_       | in  | tdata[31:0] arrival_time                  | s_tvalid & s_tready
// m_       | out | tdata[0] allow, [9:1] in_window, [10] ovf  | m_tvalid & m_tready
// cfg_     | in  | cfg_addr index, cfg_wdata value            | cfg_wr_en
// Each expiry is one read of the ring memory (ST_READ) and one compare (ST_CHECK); an item
// expires entries until the oldest is inside the window or the ring is empty, then its result
// is registered from ST_DONE. s_tready is low until then, so a new item waits for the last one.
// Reset (synchronous, aresetn low) empties the ring and loads default limits.
// A stalled m_tready holds the finished item; the next item runs up to its result and waits.
// Top level of the sliding window rate limiter; depends on swrl_pkg, swrl_ram,
// swrl_cfg_regs and sliding_window_rate_limiter_macros.svh.
`include "sliding_window_rate_limiter_macros.svh"
module sliding_window_rate_limiter import swrl_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] arrival_time
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] allow, [9:1] in_window, [10] overflow
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    cfg_t cfg;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     oldest_reg, oldest_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ARRIVAL_W-1:0] now_reg, now_next;
    logic                 ovf_reg, ovf_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 in_accept;
    logic                 full;
    logic [SUM_W-1:0]     slot_sum;
    logic [PTR_W-1:0]     slot;
    logic [PTR_W-1:0]     oldest_inc;
    logic [ARRIVAL_W-1:0] rd_data;
    logic [ARRIVAL_W-1:0] age;
    logic                 expired;
    logic                 expire_hit;
    logic                 out_free;
    logic [31:0]          count_ext;
    logic                 allow;

    swrl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(RING_DEPTH));

    assign oldest_inc = (oldest_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign slot_sum   = {1'b0, oldest_reg} + {1'b0, count_reg[PTR_W-1:0]};
    assign slot       = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                        PTR_W'(slot_sum - SUM_W'(RING_DEPTH)) : slot_sum[PTR_W-1:0];

    swrl_ram #(
        .WIDTH (ARRIVAL_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (in_accept),
        .waddr (full ? oldest_reg : slot),
        .wdata (s_tdata[ARRIVAL_W-1:0]),
        .raddr (oldest_reg),
        .rdata (rd_data)
    );

    assign age        = now_reg - rd_data;
    assign expired    = (age >= {{(ARRIVAL_W-WIN_W){1'b0}}, cfg.window_length});
    assign expire_hit = (state_reg == ST_CHECK) && expired;
    assign out_free   = !m_valid_reg || m_tready;
    assign count_ext  = 32'(count_reg);
    assign allow      = (count_ext <= 32'(cfg.max_per_window));

    always_comb begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    now_next = s_tdata[ARRIVAL_W-1:0];
                    if (full) begin
                        oldest_next = oldest_inc;
                        ovf_next    = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                        ovf_next   = 1'b0;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = (count_reg == '0) ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                if (expired) begin
                    oldest_next = oldest_inc;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({ovf_reg, count_ext[IN_WINDOW_W-1:0], allow});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            oldest_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg    <= now_next;
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SWRL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(RING_DEPTH), "count range")
    `SWRL_ASSERT_SAME(a_oldest_bound, 1'b1, oldest_reg <= PTR_W'(RING_DEPTH - 1), "pointer range")
    `SWRL_ASSERT_NEXT(a_append, in_accept, count_reg != '0, "append left ring empty")
    `SWRL_ASSERT_NEXT(a_expire, expire_hit, count_reg + 1'b1 == $past(count_reg), "expiry count")

endmodule

FILE: verif/sliding_window_rate_limiter_test.sv
// Self-checking testbench for sliding_window_rate_limiter: directed rows, then random phases.
// A local sliding-window model predicts verdicts no row fixes; uses swrl_pkg and RTL only.
`timescale 1ns / 100ps
module sliding_window_rate_limiter_test;
    import swrl_pkg::*;

    localparam int          LOG_DEPTH      = RING_DEPTH_DEF;
    localparam int          DIR_ROWS       = 24;
    localparam int          PHASES         = 7;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          TAIL_CYCLES    = 600;
    localparam int          WATCHDOG_LIMIT = 50000;
    localparam int unsigned PCT_HEAVY      = 71;
    localparam int unsigned PCT_BOTH       = 32;

    typedef enum logic [2:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH, IDLE_HOLD} idle_mode_t;
    typedef enum logic {ROW_ARRIVAL, ROW_LIMITS} row_kind_t;

    typedef struct packed {
        logic                   allow;
        logic [IN_WINDOW_W-1:0] in_window;
        logic                   overflow;
    } verdict_t;

    typedef struct packed {
        logic     fixed;
        verdict_t want;
    } verdict_hint_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [ARRIVAL_W-1:0]   stamp;
        logic [MAX_W-1:0]       lim_max;
        logic [WIN_W-1:0]       lim_win;
        logic                   fixed;
        logic                   allow;
        logic [IN_WINDOW_W-1:0] in_window;
        logic                   overflow;
    } dir_row_t;

    typedef struct packed {
        logic             rand_limits;
        logic [MAX_W-1:0] lim_max;
        logic [WIN_W-1:0] lim_win;
        logic [15:0]      step_max;
        logic [7:0]       noise_pct;
        logic [7:0]       jump_pct;
        logic [15:0]      items;
        idle_mode_t       idle;
    } phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [ARRIVAL_W-1:0] arrival_log [LOG_DEPTH];
    int unsigned          log_head = 0;
    int unsigned          log_count = 0;
    logic [MAX_W-1:0]     lim_max;
    logic [WIN_W-1:0]     lim_window;

    verdict_t      verdict_q [$];
    verdict_hint_t hint_q [$];
    idle_mode_t    idle_mode;
    int unsigned   mismatch_count = 0;
    int unsigned   stall_cycles;

    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_ARRIVAL, 32'h0000_0000, 8'd0,   16'd0,     1'b1, 1'b1, 9'd1, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_03E7, 8'd0,   16'd0,     1'b1, 1'b1, 9'd2, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_03E8, 8'd0,   16'd0,     1'b1, 1'b1, 9'd2, 1'b0},
        '{ROW_ARRIVAL, 32'hFFFF_FFFF, 8'd0,   16'd0,     1'b1, 1'b1, 9'd1, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0005, 8'd0,   16'd0,     1'b1, 1'b1, 9'd2, 1'b0},
        '{ROW_ARRIVAL, 32'hFFFF_FFF0, 8'd0,   16'd0,     1'b1, 1'b1, 9'd1, 1'b0},
        '{ROW_LIMITS,  32'h0000_0000, 8'd0,   16'd1000,  1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0010, 8'd0,   16'd0,     1'b1, 1'b0, 9'd2, 1'b0},
        '{ROW_LIMITS,  32'h0000_0000, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0020, 8'd0,   16'd0,     1'b1, 1'b1, 9'd0, 1'b0},
        '{ROW_LIMITS,  32'h0000_0000, 8'd255, 16'd65535, 1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h8000_0000, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h8000_FFFE, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h8000_FFFF, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h7FFF_FFFF, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'hFFFF_FFFF, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0000, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_LIMITS,  32'h0000_0000, 8'd1,   16'd3,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0100, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0100, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0101, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h0000_0103, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'h5555_5555, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0},
        '{ROW_ARRIVAL, 32'hAAAA_AAAA, 8'd0,   16'd0,     1'b0, 1'b0, 9'd0, 1'b0}
    };

    phase_t phases [PHASES] = '{
        '{1'b0, 8'd255, 16'd65535, 16'd1,  8'd0,  8'd0, 16'd300, IDLE_NONE},
        '{1'b0, 8'd200, 16'd300,   16'd3,  8'd3,  8'd5, 16'd200, IDLE_HOLD},
        '{1'b0, 8'd0,   16'd1,     16'd2,  8'd10, 8'd5, 16'd120, IDLE_SRC},
        '{1'b0, 8'd50,  16'd1000,  16'd40, 8'd5,  8'd8, 16'd150, IDLE_SNK},
        '{1'b1, 8'd0,   16'd0,     16'd0,  8'd5,  8'd8, 16'd150, IDLE_BOTH},
        '{1'b0, 8'd8,   16'd0,     16'd5,  8'd5,  8'd5, 16'd60,  IDLE_BOTH},
        '{1'b0, 8'd255, 16'd65535, 16'd60, 8'd0,  8'd0, 16'd300, IDLE_SRC}
    };

    sliding_window_rate_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic verdict_t predict_verdict(input logic [ARRIVAL_W-1:0] now);
        verdict_t             v;
        int unsigned          slot;
        logic [ARRIVAL_W-1:0] age;
        v = '0;
        if (log_count == LOG_DEPTH) begin
            arrival_log[log_head] = now;
            log_head = (log_head + 1) % LOG_DEPTH;
            v.overflow = 1'b1;
        end else begin
            slot = (log_head + log_count) % LOG_DEPTH;
            arrival_log[slot] = now;
            log_count++;
        end
        while (log_count != 0) begin
            age = now - arrival_log[log_head];
            if (age < 32'(lim_window))
                break;
            log_head = (log_head + 1) % LOG_DEPTH;
            log_count--;
        end
        v.allow = (log_count <= int'(lim_max));
        v.in_window = IN_WINDOW_W'(log_count);
        return v;
    endfunction

    function automatic logic [ARRIVAL_W-1:0] next_arrival(input logic [ARRIVAL_W-1:0] prev,
                                                         input phase_t ph,
                                                         input int unsigned step_max);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < ph.noise_pct)
            return ($urandom_range(0, 1) != 0) ? $urandom() : prev - $urandom_range(1, 64);
        if (pick < ph.noise_pct + ph.jump_pct)
            return prev + $urandom_range(0, 2 * int'(lim_window) + 16);
        return prev + $urandom_range(0, step_max);
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic set_limits(input logic [MAX_W-1:0] max_v, input logic [WIN_W-1:0] win_v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_MAX_PER_WINDOW;
        cfg_wdata <= {8'($urandom_range(0, 255)), max_v};
        @(posedge aclk);
        cfg_addr  <= REG_WINDOW_LENGTH;
        cfg_wdata <= win_v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lim_max    = max_v;
        lim_window = win_v;
    endtask

    task automatic send_arrival(input logic [ARRIVAL_W-1:0] stamp, input verdict_hint_t hint);
        int unsigned pct;
        pct = (idle_mode == IDLE_SRC) ? PCT_HEAVY : (idle_mode == IDLE_BOTH) ? PCT_BOTH : 0;
        while (pct != 0 && $urandom_range(0, 99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        hint_q = {hint_q, hint};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0 || hint_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : watch_ports
        verdict_hint_t hint;
        verdict_t      want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                hint = hint_q[0];
                hint_q.delete(0);
                want = predict_verdict(s_tdata);
                verdict_q = {verdict_q, (hint.fixed ? hint.want : want)};
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch("unexpected item", 0, 32'(m_tdata));
                end else begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    if (m_tdata[0] !== want.allow)
                        flag_mismatch("allow", 32'(want.allow), 32'(m_tdata[0]));
                    if (m_tdata[9:1] !== want.in_window)
                        flag_mismatch("in_window", 32'(want.in_window), 32'(m_tdata[9:1]));
                    if (m_tdata[10] !== want.overflow)
                        flag_mismatch("overflow", 32'(want.overflow), 32'(m_tdata[10]));
                    if (m_tdata[M_TDATA_W-1:11] !== '0)
                        flag_mismatch("padding", 0, 32'(m_tdata[M_TDATA_W-1:11]));
                end
            end
        end
    end

    initial begin : drive_sink
        int unsigned pct;
        logic        hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_mode == IDLE_HOLD && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                pct = (idle_mode == IDLE_SNK) ? PCT_HEAVY :
                      (idle_mode == IDLE_BOTH) ? PCT_BOTH : 0;
                m_tready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : run_test
        logic [ARRIVAL_W-1:0] cur_time;
        int unsigned          step_max;
        phase_t               ph;
        dir_row_t             row;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_MAX_PER_WINDOW;
        cfg_wdata <= '0;
        idle_mode  = IDLE_NONE;
        lim_max    = MAX_PER_WINDOW_RST;
        lim_window = WINDOW_LENGTH_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_LIMITS) begin
                wait_drained();
                set_limits(row.lim_max, row.lim_win);
            end else begin
                send_arrival(row.stamp,
                             verdict_hint_t'{row.fixed,
                                             verdict_t'{row.allow, row.in_window, row.overflow}});
            end
        end

        cur_time = $urandom();
        for (int p = 0; p < PHASES; p++) begin
            ph = phases[p];
            wait_drained();
            if (ph.rand_limits) begin
                ph.lim_max = 8'($urandom_range(0, 255));
                ph.lim_win = 16'($urandom_range(1, 2000));
                step_max   = $urandom_range(1, 50);
            end else begin
                step_max = ph.step_max;
            end
            set_limits(ph.lim_max, ph.lim_win);
            idle_mode = ph.idle;
            for (int n = 0; n < ph.items; n++) begin
                cur_time = next_arrival(cur_time, ph, step_max);
                send_arrival(cur_time, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
